[design/aes_pkg.sv]
// Package for the AES-128 block cipher: payload structs, state codes,
// S-box tables and GF(2^8) helpers. Depends on nothing.
`default_nettype none
package aes_pkg;

  localparam int unsigned RoundCountDefault = 10;
  localparam int unsigned CfgIndexWidth = 1;
  localparam logic [CfgIndexWidth-1:0] RegKeyUpper = 1'b0;
  localparam logic [CfgIndexWidth-1:0] RegKeyLower = 1'b1;

  typedef struct packed {
    logic        decrypt;
    logic [63:0] block_upper;
    logic [63:0] block_lower;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_upper;
    logic [63:0] result_lower;
  } aes_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_OUT
  } aes_state_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // One output byte of MixColumns or InvMixColumns for a column a0..a3,
  // taken in row order starting at the output row.
  function automatic logic [7:0] mix_byte(input logic [7:0] a0, input logic [7:0] a1,
                                          input logic [7:0] a2, input logic [7:0] a3,
                                          input logic inv);
    logic [7:0] d0, q0, o0, d1, q1, o1, d2, q2, o2, d3, q3, o3;
    d0 = xtime(a0); q0 = xtime(d0); o0 = xtime(q0);
    d1 = xtime(a1); q1 = xtime(d1); o1 = xtime(q1);
    d2 = xtime(a2); q2 = xtime(d2); o2 = xtime(q2);
    d3 = xtime(a3); q3 = xtime(d3); o3 = xtime(q3);
    if (inv) begin
      // 14, 11, 13, 9
      return (o0 ^ q0 ^ d0) ^ (o1 ^ d1 ^ a1) ^ (o2 ^ q2 ^ a2) ^ (o3 ^ a3);
    end
    return d0 ^ (d1 ^ a1) ^ a2 ^ a3;
  endfunction

endpackage
`default_nettype wire

[design/aes128_block_cipher.sv]
// Top level of the AES-128 block cipher (ECB, encrypt and decrypt).
// Depends on aes_pkg for payload structs, state codes and S-box tables.
`default_nettype none
// The key is written as two 64-bit registers (index 0 upper, index 1 lower)
// while the block is idle. A key write that is offered together with a word
// goes first, because the word is held off while the write is pending. Any
// key write marks the round-key schedule stale. The next accepted word then
// first expands the key into 4*(ROUND_COUNT+1) round-key words, one word per
// cycle, into a single-port 32-bit key memory. Each block then passes a load
// state and fetches every round key as four words, because the memory
// returns one 32-bit word per cycle (11 round keys for ROUND_COUNT 10). A
// final state moves the result into the output register once that is free.
// One word is worked on at a time. The next word may be accepted while the
// previous result still waits in the output register; the new result is
// then held back until that one has been taken.
module aes128_block_cipher #(
  parameter int unsigned ROUND_COUNT = aes_pkg::RoundCountDefault
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire aes_pkg::aes_in_t            in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output aes_pkg::aes_out_t                out_data,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [aes_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire [63:0]                       cfg_data
);
  import aes_pkg::*;

  localparam int unsigned KeyWords = 4 * (ROUND_COUNT + 1);
  localparam int unsigned AddrW = $clog2(KeyWords);
  localparam int unsigned RndW = $clog2(ROUND_COUNT + 1);

  logic [63:0] key_upper, key_lower;
  logic        schedule_valid;

  aes_state_t state, state_next;

  // Round-key memory, read one word per cycle; the read data is registered.
  logic [31:0] key_mem [KeyWords];
  logic [AddrW-1:0] mem_addr;
  logic [31:0] mem_wdata, mem_rdata;
  logic        mem_we;

  // Expansion: the last four words are kept in registers.
  logic [AddrW-1:0] exp_idx;
  logic [31:0] w0, w1, w2, w3;
  logic [7:0]  rcon;

  // Round datapath.
  logic [RndW-1:0] rnd;
  logic [1:0]      col;
  logic [127:0]    st;
  logic [95:0]     acc;
  logic            dec;
  logic            out_full;

  logic in_fire, out_fire, out_load;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = (state != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign out_valid = out_full;
  // The finished word moves to the output register once that is free.
  assign out_load = (state == ST_OUT) && (!out_full || out_fire);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= key_mem[mem_addr];
  end

  // Next expanded word from the previous four.
  logic [31:0] exp_t, exp_word;
  always_comb begin
    exp_t = w3;
    if (exp_idx[1:0] == 2'd0) begin
      exp_t = {sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])}
              ^ {rcon, 24'h0};
    end
    exp_word = w0 ^ exp_t;
  end

  // Round computation on st with round index rnd (byte i = st[127-8i -: 8]).
  logic [7:0] sb [16];
  logic [7:0] mx [16];
  logic [127:0] round_pre; // state before AddRoundKey of this round
  logic [127:0] round_key;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (dec) begin
          sb[4 * ((c + r) % 4) + r] = inv_sbox(st[127 - 8 * (4 * c + r) -: 8]);
        end else begin
          sb[4 * c + r] = sbox(st[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]);
        end
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        mx[4 * c + r] = mix_byte(sb[4 * c + r], sb[4 * c + (r + 1) % 4],
                                 sb[4 * c + (r + 2) % 4], sb[4 * c + (r + 3) % 4], 1'b0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      round_pre[127 - 8 * i -: 8] = sb[i];
    end
    if (!dec && rnd != RndW'(ROUND_COUNT)) begin
      for (int i = 0; i < 16; i++) begin
        round_pre[127 - 8 * i -: 8] = mx[i];
      end
    end
    round_key = {acc, mem_rdata};
  end

  // Inverse mix on the key-added state for decryption.
  logic [127:0] dec_added, dec_mixed;
  always_comb begin
    dec_added = round_pre ^ round_key;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        dec_mixed[127 - 8 * (4 * c + r) -: 8] = mix_byte(
          dec_added[127 - 8 * (4 * c + r) -: 8],
          dec_added[127 - 8 * (4 * c + (r + 1) % 4) -: 8],
          dec_added[127 - 8 * (4 * c + (r + 2) % 4) -: 8],
          dec_added[127 - 8 * (4 * c + (r + 3) % 4) -: 8], 1'b1);
      end
    end
  end

  // Key words of a round are fetched one at a time into acc; each word
  // shifts in, the round completes when the fourth word lands.
  logic [RndW-1:0] key_round;
  assign key_round = dec ? RndW'(ROUND_COUNT) - rnd : rnd;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = schedule_valid ? ST_LOAD : ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        if (exp_idx == AddrW'(KeyWords - 1)) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD:  state_next = ST_ROUND;
      ST_ROUND: begin
        if (col == 2'd3 && rnd == RndW'(ROUND_COUNT)) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wdata = exp_word;
    mem_addr = AddrW'({key_round, col} + (RndW + 2)'(1));
    case (state)
      ST_EXPAND: begin
        mem_we = 1'b1;
        mem_addr = exp_idx;
        mem_wdata = (exp_idx < AddrW'(4)) ? w0 : exp_word;
      end
      ST_LOAD: begin
        mem_addr = AddrW'({(dec ? RndW'(ROUND_COUNT) : RndW'(0)), 2'd0});
      end
      ST_ROUND: begin
        if (col == 2'd3) begin
          mem_addr = AddrW'({(dec ? key_round - RndW'(1) : key_round + RndW'(1)), 2'd0});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      key_upper <= '0;
      key_lower <= '0;
      schedule_valid <= 1'b0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegKeyUpper: begin key_upper <= cfg_data; schedule_valid <= 1'b0; end
          RegKeyLower: begin key_lower <= cfg_data; schedule_valid <= 1'b0; end
          default: ;
        endcase
      end
      if (state == ST_EXPAND && exp_idx == AddrW'(KeyWords - 1)) begin
        schedule_valid <= 1'b1;
      end
      if (out_load) begin
        out_full <= 1'b1;
      end else if (out_fire) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        st  <= {in_data.block_upper, in_data.block_lower};
        dec <= in_data.decrypt;
        exp_idx <= '0;
        rcon <= 8'h01;
        {w0, w1, w2, w3} <= {key_upper, key_lower};
      end
      ST_EXPAND: begin
        exp_idx <= exp_idx + AddrW'(1);
        if (exp_idx < AddrW'(4)) begin
          {w0, w1, w2, w3} <= {w1, w2, w3, w0};
        end else begin
          {w0, w1, w2, w3} <= {w1, w2, w3, exp_word};
          if (exp_idx[1:0] == 2'd0) begin
            rcon <= xtime(rcon);
          end
        end
      end
      ST_LOAD: begin
        rnd <= '0;
        col <= 2'd0;
      end
      ST_ROUND: begin
        acc <= {acc[63:0], mem_rdata};
        col <= col + 2'd1;
        if (col == 2'd3) begin
          if (rnd == '0) begin
            st <= st ^ round_key;
          end else if (dec && rnd != RndW'(ROUND_COUNT)) begin
            st <= dec_mixed;
          end else begin
            st <= dec_added;
          end
          rnd <= rnd + RndW'(1);
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_data.result_upper <= st[127:64];
          out_data.result_lower <= st[63:0];
        end
      end
      default: ;
    endcase
  end

  // Memory address sequencing: in ST_ROUND col 0..2 read the next words of
  // the current round, col 3 prefetches word 0 of the following round.
  // Address of col k is base+k+1 for k<3, covered by the default above.

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_fire) else $error("word accepted while busy");
  a_expand_leads_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXPAND && state_next == ST_LOAD) |=> schedule_valid)
    else $error("schedule not marked valid");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_data))
    else $error("result dropped");
  a_no_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> !cfg_ready) else $error("config open mid block");

endmodule
`default_nettype wire
